>>> hdl/mict_pkg.sv
// Shared types and constants for the multiset intersection count table.
// Used by mict_ctrl, mict_dp and multiset_intersect_count_table.
package mict_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PROBE = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

>>> hdl/mict_ctrl.sv
// Sequencer for the count table: accept, search, commit, deliver.
// Depends on mict_pkg; drives mict_dp through ctrl_cmd_t.
module mict_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  mict_pkg::dp_stat_t  stat,
  output mict_pkg::ctrl_cmd_t cmd
);
  import mict_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.step   = !stat.done;
        cmd.commit = stat.done;
        if (stat.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/mict_dp.sv
// Datapath of the count table: key and count memories, scan pointer,
// compare stage, update logic and result registers. Depends on mict_pkg.
module mict_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mict_pkg::ctrl_cmd_t               cmd,
  output mict_pkg::dp_stat_t                stat,
  input  logic [1:0]                        in_action,
  input  logic [mict_pkg::VALUE_W-1:0]      in_value,
  output logic                              res_hit,
  output logic [mict_pkg::VALUE_W-1:0]      res_value,
  output logic [1:0]                        res_status
);
  import mict_pkg::*;

  logic [VALUE_W-1:0]     key_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];

  logic [1:0]             act_r;
  logic [VALUE_W-1:0]     key_r;
  logic [USED_W-1:0]      used_r, used_nxt;
  logic [USED_W-1:0]      idx_r;
  logic                   cmp_vld_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic [VALUE_W-1:0]     key_q;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   hit_r, hit_nxt;
  logic [1:0]             status_r, status_nxt;

  logic                   is_srch, found, miss, rd_en;
  logic                   key_we, cnt_we;
  logic [IDX_W-1:0]       cnt_wa;
  logic [COUNT_WIDTH-1:0] cnt_wd;

  assign is_srch = (act_r == ACT_LOAD) || (act_r == ACT_PROBE);
  assign found   = cmp_vld_r && (key_q == key_r);
  assign miss    = !cmp_vld_r && (idx_r >= used_r);
  assign stat.done = !is_srch || found || miss;
  assign rd_en   = cmd.step && (idx_r < used_r);

  always_comb begin
    hit_nxt    = 1'b0;
    status_nxt = STAT_OK;
    used_nxt   = used_r;
    key_we     = 1'b0;
    cnt_we     = 1'b0;
    cnt_wa     = cmp_idx_r;
    cnt_wd     = cnt_q + COUNT_WIDTH'(1);
    unique case (act_r)
      ACT_CLEAR: used_nxt = '0;
      ACT_LOAD: begin
        if (found) begin
          if (cnt_q == {COUNT_WIDTH{1'b1}}) begin
            status_nxt = STAT_SAT;
          end else begin
            cnt_we = 1'b1;
          end
        end else if (used_r == USED_W'(TABLE_DEPTH)) begin
          status_nxt = STAT_FULL;
        end else begin
          key_we   = 1'b1;
          cnt_we   = 1'b1;
          cnt_wa   = used_r[IDX_W-1:0];
          cnt_wd   = COUNT_WIDTH'(1);
          used_nxt = used_r + USED_W'(1);
        end
      end
      ACT_PROBE: begin
        if (found && (cnt_q != '0)) begin
          hit_nxt = 1'b1;
          cnt_we  = 1'b1;
          cnt_wd  = cnt_q - COUNT_WIDTH'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && key_we) key_mem[used_r[IDX_W-1:0]] <= key_r;
    if (rd_en) key_q <= key_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (rd_en) cnt_q <= cnt_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      idx_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r     <= '0;
        cmp_vld_r <= 1'b0;
      end else if (cmd.step) begin
        cmp_vld_r <= rd_en;
        if (rd_en) idx_r <= idx_r + USED_W'(1);
      end
      if (cmd.commit) used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_action;
      key_r <= in_value;
    end
    if (cmd.step && rd_en) cmp_idx_r <= idx_r[IDX_W-1:0];
    if (cmd.commit) begin
      hit_r    <= hit_nxt;
      status_r <= status_nxt;
    end
  end

  assign res_hit    = hit_r;
  assign res_value  = key_r;
  assign res_status = status_r;

endmodule

>>> hdl/multiset_intersect_count_table.sv
// Top level of the multiset intersection count table.
// Depends on mict_pkg, mict_ctrl and mict_dp.
// Usage:
//   Input words carry an action in in_tuser and a 32-bit element in
//   in_tdata. Load adds the element of the first multiset to the table,
//   probe consumes one matching count of the second multiset and reports
//   a hit, clear empties the table. Every input word gives one output word
//   with the echoed element in out_tdata and hit and status in out_tuser.
// Timing:
//   One word is in flight at a time. A search ends on a hit or when
//   every stored entry has been scanned; an empty table needs no scan.
//   The scan reads one key per cycle and compares it in the cycle after,
//   so a full table of 64 entries sets the worst case. Clear and unused
//   actions skip the scan.
// Reset and stalls:
//   Synchronous reset empties the table and returns to idle. While the
//   output word waits for out_tready, in_tready stays low and the result
//   holds.
module multiset_intersect_count_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic [2:0]  out_tuser   // [0] hit, [2:1] status
);
  import mict_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      res_hit;
  logic [1:0] res_status;

  mict_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mict_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (in_tuser),
    .in_value   (in_tdata),
    .res_hit    (res_hit),
    .res_value  (out_tdata),
    .res_status (res_status)
  );

  assign out_tuser = {res_status, res_hit};

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while a result is pending");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result presented before the search ran");

  a_hit_has_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == STAT_OK))
    else $error("hit reported with an error status");

  a_step_commit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.commit) && !(cmd.accept && (cmd.step || cmd.commit)))
    else $error("controller issued conflicting commands");

endmodule
